// File: sv/ppbm_pkg.sv
`timescale 1ns / 1ps

package ppbm_pkg;

    // event kinds carried on the input tuser
    typedef enum logic [2:0] {
        MODE_BYTE       = 3'd0,
        MODE_TICK       = 3'd1,
        MODE_POLL       = 3'd2,
        MODE_WR_DONE    = 3'd3,
        MODE_LINK_RESET = 3'd4,
        MODE_RESTART    = 3'd5
    } t_mode;

    // register map
    localparam int          CFG_W            = 10;
    localparam int          PADDR_W          = 3;
    localparam logic        REG_CHUNK_SIZE   = 1'b0;
    localparam logic [9:0]  CHUNK_SIZE_RESET = 10'd512;

    // stream widths
    localparam int IN_TDATA_W  = 16;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 64;

    // one input event
    typedef struct packed {
        t_mode      mode;
        logic [7:0] data_byte;
        logic       link_up;
    } t_item;

    // one result
    typedef struct packed {
        logic        write_valid;
        logic        write_buffer;
        logic [8:0]  write_offset;
        logic [7:0]  write_data;
        logic        send_valid;
        logic        send_buffer;
        logic [9:0]  send_length;
        logic [31:0] overrun_total;
    } t_result;

    // result packed into tdata, first field in the lowest bits
    function automatic logic [OUT_TDATA_W-1:0] pack_result(input t_result r);
        pack_result = {1'b0, r.overrun_total, r.send_length, r.send_buffer, r.send_valid,
                       r.write_data, r.write_offset, r.write_buffer, r.write_valid};
    endfunction

endpackage

// File: sv/ppbm_apb_regs.sv
`timescale 1ns / 1ps

module ppbm_apb_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ppbm_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output logic [ppbm_pkg::CFG_W-1:0]   o_chunk_size
);
    import ppbm_pkg::*;

    logic [CFG_W-1:0] r_chunk_size;
    logic             wr_en;

    // write strobe in the access phase
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_CHUNK_SIZE);

    // chunk size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_size <= CHUNK_SIZE_RESET;
        end else if (wr_en) begin
            r_chunk_size <= pwdata[CFG_W-1:0];
        end
    end

    // read back
    always_comb begin
        if (paddr[2] == REG_CHUNK_SIZE) begin
            prdata = 32'(r_chunk_size);
        end else begin
            prdata = '0;
        end
    end

    assign o_chunk_size = r_chunk_size;

endmodule

// File: sv/ppbm_core.sv
`timescale 1ns / 1ps

module ppbm_core #(
    parameter int CHUNK_BYTES = 512
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_fire,
    input  ppbm_pkg::t_item            i_item,
    input  logic [ppbm_pkg::CFG_W-1:0] i_chunk_size,
    output ppbm_pkg::t_result          o_result
);
    import ppbm_pkg::*;

    localparam int CW = $clog2(CHUNK_BYTES + 1);
    localparam int EW = (CW > CFG_W) ? CW : CFG_W;
    localparam logic [EW-1:0] LIMIT = EW'(CHUNK_BYTES);

    // buffer state
    logic [CW-1:0] r_pend0, n_pend0;
    logic [CW-1:0] r_pend1, n_pend1;
    logic          r_fill_idx, n_fill_idx;
    logic          r_send_idx, n_send_idx;
    logic          r_infl_idx, n_infl_idx;
    logic          r_send_busy, n_send_busy;
    logic [CW-1:0] r_fill_count, n_fill_count;
    logic [31:0]   r_dropped, n_dropped;

    logic [EW-1:0] eff_chunk;
    logic [EW-1:0] cs_ext;
    logic [CW-1:0] cnt_inc;
    logic [EW-1:0] fc_ext;
    logic          do_hand;
    logic [CW-1:0] hand_cnt;
    logic [CW-1:0] pend_other;
    logic [32:0]   drop_sum;
    logic          poll_idx;
    logic [CW-1:0] poll_len;
    logic [EW-1:0] poll_len_ext;

    // chunk size clamped to 1 .. CHUNK_BYTES
    always_comb begin
        cs_ext = EW'(i_chunk_size);
        if (cs_ext == '0) begin
            eff_chunk = EW'(1);
        end else if (cs_ext > LIMIT) begin
            eff_chunk = LIMIT;
        end else begin
            eff_chunk = cs_ext;
        end
    end

    assign cnt_inc    = r_fill_count + CW'(1);
    assign fc_ext     = EW'(r_fill_count);
    assign pend_other = r_fill_idx ? r_pend0 : r_pend1;

    // poll picks send index, else the other buffer if only that one holds data
    always_comb begin
        logic [CW-1:0] len_a;
        logic [CW-1:0] len_b;
        len_a = r_send_idx ? r_pend1 : r_pend0;
        len_b = r_send_idx ? r_pend0 : r_pend1;
        if (len_a == '0 && len_b != '0) begin
            poll_idx = ~r_send_idx;
            poll_len = len_b;
        end else begin
            poll_idx = r_send_idx;
            poll_len = len_a;
        end
    end

    assign poll_len_ext = EW'(poll_len);

    // next state and result for the event at hand
    always_comb begin
        n_pend0      = r_pend0;
        n_pend1      = r_pend1;
        n_fill_idx   = r_fill_idx;
        n_send_idx   = r_send_idx;
        n_infl_idx   = r_infl_idx;
        n_send_busy  = r_send_busy;
        n_fill_count = r_fill_count;
        n_dropped    = r_dropped;
        do_hand      = 1'b0;
        hand_cnt     = r_fill_count;
        drop_sum     = {1'b0, r_dropped} + 33'(hand_cnt);
        o_result     = '0;

        if (i_fire) begin
            case (i_item.mode)
                MODE_BYTE: begin
                    o_result.write_valid  = 1'b1;
                    o_result.write_buffer = r_fill_idx;
                    o_result.write_offset = fc_ext[8:0];
                    o_result.write_data   = i_item.data_byte;
                    n_fill_count          = cnt_inc;
                    hand_cnt              = cnt_inc;
                    do_hand               = (EW'(cnt_inc) >= eff_chunk);
                end
                MODE_TICK: begin
                    do_hand = (r_fill_count != '0);
                end
                MODE_POLL: begin
                    if (i_item.link_up && !r_send_busy && poll_len != '0) begin
                        n_send_busy          = 1'b1;
                        n_infl_idx           = poll_idx;
                        o_result.send_valid  = 1'b1;
                        o_result.send_buffer = poll_idx;
                        o_result.send_length = poll_len_ext[9:0];
                    end
                end
                MODE_WR_DONE: begin
                    if (r_send_busy) begin
                        n_send_busy = 1'b0;
                        n_send_idx  = ~r_infl_idx;
                        if (r_infl_idx) begin
                            n_pend1 = '0;
                        end else begin
                            n_pend0 = '0;
                        end
                    end
                end
                MODE_LINK_RESET: begin
                    n_send_busy = 1'b0;
                end
                MODE_RESTART: begin
                    n_pend0      = '0;
                    n_pend1      = '0;
                    n_fill_idx   = 1'b0;
                    n_send_idx   = 1'b0;
                    n_fill_count = '0;
                end
                default: begin
                end
            endcase
        end

        // hand the fill buffer over, or drop its bytes when the other is still pending
        drop_sum = {1'b0, r_dropped} + 33'(hand_cnt);
        if (do_hand) begin
            if (pend_other == '0) begin
                if (r_fill_idx) begin
                    n_pend1 = hand_cnt;
                end else begin
                    n_pend0 = hand_cnt;
                end
                n_fill_idx = ~r_fill_idx;
            end else begin
                n_dropped = drop_sum[32] ? '1 : drop_sum[31:0];
            end
            n_fill_count = '0;
        end

        o_result.overrun_total = n_dropped;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend0      <= '0;
            r_pend1      <= '0;
            r_fill_idx   <= 1'b0;
            r_send_idx   <= 1'b0;
            r_infl_idx   <= 1'b0;
            r_send_busy  <= 1'b0;
            r_fill_count <= '0;
            r_dropped    <= '0;
        end else begin
            r_pend0      <= n_pend0;
            r_pend1      <= n_pend1;
            r_fill_idx   <= n_fill_idx;
            r_send_idx   <= n_send_idx;
            r_infl_idx   <= n_infl_idx;
            r_send_busy  <= n_send_busy;
            r_fill_count <= n_fill_count;
            r_dropped    <= n_dropped;
        end
    end

    // a partial chunk never reaches the buffer size
    a_fill_below_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        EW'(r_fill_count) < LIMIT)
        else $error("fill count reached buffer size");

    // a descriptor marks the buffer in flight
    a_send_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_result.send_valid |=> r_send_busy && (r_infl_idx == $past(poll_idx)))
        else $error("send descriptor without busy flag");

    // overrun total only grows
    a_drop_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> r_dropped >= $past(r_dropped))
        else $error("overrun total decreased");

    // fill buffer only swaps on an event
    a_fill_idx_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> $stable(r_fill_idx) && $stable(r_fill_count))
        else $error("fill state changed without an event");

endmodule

// File: sv/ping_pong_rx_buffer_manager.sv
`timescale 1ns / 1ps

// Ping-pong receive buffer manager. Each input event (byte, tick flush, send poll,
// write complete, link reset, restart) yields exactly one result carrying a byte
// write address, a send descriptor and the saturating overrun total. One event is
// taken every clock cycle while the result output is not stalled: the buffer state
// is updated combinationally between the input register and the result register.
// The chunk size register is written over APB at address 0; writing it only while
// the block is idle is up to the user, as the block itself does not enforce it.
module ping_pong_rx_buffer_manager #(
    parameter int CHUNK_BYTES = 512
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input events
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [ppbm_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,   // data_byte[7:0], link_up[8]
    input  logic [ppbm_pkg::IN_TUSER_W-1:0]  i_s_axis_tuser,   // mode[2:0]
    // results
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [ppbm_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,   // write_valid[0],
                                                               // write_buffer[1],
                                                               // write_offset[10:2],
                                                               // write_data[18:11],
                                                               // send_valid[19],
                                                               // send_buffer[20],
                                                               // send_length[30:21],
                                                               // overrun_total[62:31]
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ppbm_pkg::PADDR_W-1:0]     paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import ppbm_pkg::*;

    logic                   r_in_valid;
    t_item                  r_in_item;
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic                   out_ready;
    logic                   in_ready;
    logic                   fire;
    logic [CFG_W-1:0]       chunk_size;
    t_result                result;

    // configuration registers
    ppbm_apb_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_chunk_size (chunk_size)
    );

    // pipeline flow control
    assign out_ready       = !r_out_valid || i_m_axis_tready;
    assign in_ready        = !r_in_valid || out_ready;
    assign fire            = r_in_valid && out_ready;
    assign o_s_axis_tready = in_ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_s_axis_tvalid) begin
            r_in_item.mode      <= t_mode'(i_s_axis_tuser);
            r_in_item.data_byte <= i_s_axis_tdata[7:0];
            r_in_item.link_up   <= i_s_axis_tdata[8];
        end
    end

    // buffer state and decision logic
    ppbm_core #(
        .CHUNK_BYTES (CHUNK_BYTES)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_item       (r_in_item),
        .i_chunk_size (chunk_size),
        .o_result     (result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_data <= pack_result(result);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import ppbm_pkg::*;

    // event codes the package leaves unnamed
    localparam logic [2:0] MODE_SPARE_6 = 3'd6;
    localparam logic [2:0] MODE_SPARE_7 = 3'd7;

    localparam int MAX_CHUNK     = 512;
    localparam int DUT_LATENCY   = 2;
    localparam int SETTLE_CYCLES = 4 * DUT_LATENCY;
    localparam int QUIET_LIMIT   = 2000;
    localparam int REPORT_MAX    = 10;
    localparam int PHASE_EVENTS  = 70;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PERIODIC,
        RX_SPARSE
    } t_rx_style;

    logic                   i_clk    = 1'b0;
    logic                   i_rst_n  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic [IN_TUSER_W-1:0]  s_tuser  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [PADDR_W-1:0]     paddr    = '0;
    logic [31:0]            pwdata   = '0;
    logic [31:0]            prdata;
    logic                   pready;

    // buffer manager state as the scoreboard sees it
    logic [9:0]  chunk_reg   = CHUNK_SIZE_RESET;
    logic [9:0]  held_len [2] = '{default: '0};
    logic        fill_buf    = 1'b0;
    logic        next_send   = 1'b0;
    logic        flight_buf  = 1'b0;
    logic        sending     = 1'b0;
    logic [9:0]  fill_cnt    = '0;
    logic [31:0] dropped     = '0;

    t_result   expected_results [$];
    int        mismatch_count   = 0;
    int        n_events         = 0;
    int        n_results        = 0;
    int        n_sends          = 0;
    int        n_handovers      = 0;
    int        n_dropped_chunks = 0;
    int        burst_left       = 0;
    int        quiet_cycles     = 0;
    int        rx_cycle         = 0;
    t_rx_style rx_style         = RX_ALWAYS;

    ping_pong_rx_buffer_manager #(
        .CHUNK_BYTES(MAX_CHUNK)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tuser (s_tuser),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic report(string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) begin
            $display("%s", msg);
        end
    endtask

    function automatic string show_result(t_result r);
        return $sformatf("wr=%0d buf=%0d off=%0d data=%h send=%0d sbuf=%0d len=%0d ovr=%0d",
                         r.write_valid, r.write_buffer, r.write_offset, r.write_data,
                         r.send_valid, r.send_buffer, r.send_length, r.overrun_total);
    endfunction

    // close the fill buffer: hand it over if the other one is free, else drop it
    function automatic void close_fill();
        logic [32:0] sum;
        if (held_len[~fill_buf] == '0) begin
            held_len[fill_buf] = fill_cnt;
            fill_buf = ~fill_buf;
            n_handovers++;
        end else begin
            sum = {1'b0, dropped} + fill_cnt;
            dropped = sum[32] ? '1 : sum[31:0];
            n_dropped_chunks++;
        end
        fill_cnt = '0;
    endfunction

    // advance the buffer state by one event and return the result it causes
    function automatic t_result buffer_step(logic [2:0] mode, logic [7:0] data, logic link);
        t_result    r;
        logic [9:0] limit;
        logic       pick;
        r = '0;
        limit = (chunk_reg == '0) ? 10'd1 :
                (chunk_reg > MAX_CHUNK) ? 10'(MAX_CHUNK) : chunk_reg;
        case (mode)
            MODE_BYTE: begin
                r.write_valid  = 1'b1;
                r.write_buffer = fill_buf;
                r.write_offset = fill_cnt[8:0];
                r.write_data   = data;
                fill_cnt++;
                if (fill_cnt >= limit) close_fill();
            end
            MODE_TICK: begin
                if (fill_cnt != '0) close_fill();
            end
            MODE_POLL: begin
                if (link && !sending) begin
                    // prefer the scheduled buffer, fall back to the other one
                    pick = next_send;
                    if (held_len[pick] == '0 && held_len[~pick] != '0) pick = ~pick;
                    if (held_len[pick] != '0) begin
                        sending       = 1'b1;
                        flight_buf    = pick;
                        r.send_valid  = 1'b1;
                        r.send_buffer = pick;
                        r.send_length = held_len[pick];
                        n_sends++;
                    end
                end
            end
            MODE_WR_DONE: begin
                if (sending) begin
                    sending              = 1'b0;
                    held_len[flight_buf] = '0;
                    next_send            = ~flight_buf;
                end
            end
            MODE_LINK_RESET: begin
                sending = 1'b0;
            end
            MODE_RESTART: begin
                held_len[0] = '0;
                held_len[1] = '0;
                fill_buf    = 1'b0;
                next_send   = 1'b0;
                fill_cnt    = '0;
            end
            default: begin
            end
        endcase
        r.overrun_total = dropped;
        return r;
    endfunction

    // one event transfer, then maybe a gap between bursts
    task automatic send_event(logic [2:0] mode, logic [7:0] data, logic link);
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'({link, data});
        s_tuser  <= mode;
        do @(posedge i_clk); while (!s_tready);
        expected_results.push_back(buffer_step(mode, data, link));
        n_events++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(0, 12);
        end
    endtask

    // hold off the sender until every result is back, then let the pipe settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_access(logic wr, logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= PADDR_W'(4 * REG_CHUNK_SIZE);
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // write the chunk size with junk above the field, then read it back
    task automatic set_chunk_size(logic [9:0] value);
        logic [31:0] junk;
        logic [31:0] rd;
        junk = $urandom;
        drain();
        apb_access(1'b1, {junk[31:CFG_W], value}, rd);
        chunk_reg = value;
        apb_access(1'b0, '0, rd);
        if (rd[CFG_W-1:0] !== chunk_reg) begin
            report($sformatf("chunk size readback: expected %0d, got %0d",
                             chunk_reg, rd[CFG_W-1:0]));
        end
    endtask

    task automatic test_register_reset();
        logic [31:0] rd;
        apb_access(1'b0, '0, rd);
        if (rd[CFG_W-1:0] !== CHUNK_SIZE_RESET) begin
            report($sformatf("chunk size after reset: expected %0d, got %0d",
                             CHUNK_SIZE_RESET, rd[CFG_W-1:0]));
        end
    endtask

    // every event kind at least once, busy and link-down polls, stray completions
    task automatic test_event_kinds();
        send_event(MODE_BYTE, 8'h00, 1'b0);
        send_event(MODE_BYTE, 8'hff, 1'b1);
        send_event(MODE_TICK, 8'h00, 1'b1);
        send_event(MODE_TICK, 8'hff, 1'b0);
        send_event(MODE_POLL, 8'h00, 1'b0);
        send_event(MODE_POLL, 8'h00, 1'b1);
        send_event(MODE_POLL, 8'h00, 1'b1);
        send_event(MODE_LINK_RESET, 8'h00, 1'b1);
        send_event(MODE_POLL, 8'h00, 1'b1);
        send_event(MODE_WR_DONE, 8'h00, 1'b1);
        send_event(MODE_WR_DONE, 8'h00, 1'b1);
        send_event(MODE_SPARE_6, 8'ha5, 1'b1);
        send_event(MODE_SPARE_7, 8'h5a, 1'b0);
        send_event(MODE_BYTE, 8'h5a, 1'b1);
        send_event(MODE_RESTART, 8'h00, 1'b1);
        send_event(MODE_POLL, 8'h00, 1'b1);
    endtask

    // chunk size lowered below the fill level: the next byte closes the chunk
    task automatic test_chunk_shrink();
        repeat (5) send_event(MODE_BYTE, 8'($urandom), 1'b1);
        set_chunk_size(10'd2);
        send_event(MODE_BYTE, 8'($urandom), 1'b1);
        send_event(MODE_POLL, 8'h00, 1'b1);
        send_event(MODE_WR_DONE, 8'h00, 1'b1);
    endtask

    // zero chunk size acts as one byte; both buffers busy drops bytes
    task automatic test_overrun_drop();
        set_chunk_size(10'd0);
        repeat (3) send_event(MODE_BYTE, 8'($urandom), 1'b1);
        send_event(MODE_TICK, 8'h00, 1'b1);
        send_event(MODE_POLL, 8'h00, 1'b1);
        send_event(MODE_WR_DONE, 8'h00, 1'b1);
        send_event(MODE_BYTE, 8'($urandom), 1'b1);
        send_event(MODE_POLL, 8'h00, 1'b1);
    endtask

    // oversized register clamps to a full buffer: offsets up to the top
    task automatic test_full_chunk();
        set_chunk_size(10'h3ff);
        send_event(MODE_RESTART, 8'h00, 1'b1);
        repeat (MAX_CHUNK) send_event(MODE_BYTE, 8'($urandom), 1'($urandom));
        send_event(MODE_POLL, 8'h00, 1'b1);
        send_event(MODE_WR_DONE, 8'h00, 1'b1);
    endtask

    task automatic random_event();
        int         w;
        logic [2:0] mode;
        w = $urandom_range(0, 99);
        if (w < 58)      mode = MODE_BYTE;
        else if (w < 68) mode = MODE_TICK;
        else if (w < 80) mode = MODE_POLL;
        else if (w < 91) mode = MODE_WR_DONE;
        else if (w < 95) mode = MODE_LINK_RESET;
        else if (w < 97) mode = MODE_RESTART;
        else if (w < 99) mode = MODE_SPARE_6;
        else             mode = MODE_SPARE_7;
        send_event(mode, 8'($urandom), $urandom_range(0, 4) != 0);
    endtask

    // mixed traffic over several chunk sizes
    task automatic test_random_traffic();
        logic [9:0] sizes [6];
        sizes = '{10'd1, 10'd2, 10'($urandom_range(3, 16)), 10'($urandom_range(17, 64)),
                  10'd0, 10'($urandom_range(3, 8))};
        foreach (sizes[p]) begin
            set_chunk_size(sizes[p]);
            for (int i = 0; i < PHASE_EVENTS; i++) begin
                if (p == 2 && i == PHASE_EVENTS / 2) drain();
                random_event();
            end
        end
    endtask

    // receiver backpressure, in one of four styles that is picked anew at random
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 128 == 0) rx_style <= t_rx_style'($urandom_range(0, 3));
        case (rx_style)
            RX_ALWAYS:   m_tready <= 1'b1;
            RX_RANDOM:   m_tready <= ($urandom_range(0, 9) < 7);
            RX_PERIODIC: m_tready <= (rx_cycle % 5 != 0);
            default:     m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_result got;
        t_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got.write_valid   = m_tdata[0];
            got.write_buffer  = m_tdata[1];
            got.write_offset  = m_tdata[10:2];
            got.write_data    = m_tdata[18:11];
            got.send_valid    = m_tdata[19];
            got.send_buffer   = m_tdata[20];
            got.send_length   = m_tdata[30:21];
            got.overrun_total = m_tdata[62:31];
            n_results++;
            if (expected_results.size() == 0) begin
                report($sformatf("unexpected result: %s", show_result(got)));
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    report($sformatf("result %0d mismatch\n  exp %s\n  got %s",
                                     n_results, show_result(want), show_result(got)));
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout with %0d results outstanding", expected_results.size());
            $display("tb: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_register_reset();
        test_event_kinds();
        test_chunk_shrink();
        test_overrun_drop();
        test_full_chunk();
        test_random_traffic();
        drain();
        $display("summary: %0d events, %0d results, %0d send descriptors",
                 n_events, n_results, n_sends);
        $display("summary: %0d chunks handed over, %0d chunks dropped, %0d bytes overrun",
                 n_handovers, n_dropped_chunks, dropped);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
